// ===== rtl/core/cdg_pkg.sv =====
// shared types, constants and lookup functions for the clock divider governor
`default_nettype none

package cdg_pkg;

    // item kinds carried on the input tuser
    typedef enum logic [1:0] {
        MODE_SAMPLE   = 2'd0,
        MODE_MAX_PERF = 2'd1,
        MODE_MANUAL   = 2'd2
    } mode_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_MANUAL_CONTROL   = 3'd0,
        REG_WINDOW_SAMPLES   = 3'd1,
        REG_LONG_TASK_US     = 3'd2,
        REG_HIGH_LOAD_LIMIT  = 3'd3,
        REG_LOW_LOAD_LIMIT   = 3'd4,
        REG_ROOM_PER_DIVIDER = 3'd5
    } reg_idx_t;

    localparam int CfgIndexW = 3;
    localparam int CfgDataW  = 20;
    localparam int InDataW   = 56;
    localparam int OutDataW  = 24;

    // configuration reset values
    localparam logic        RST_MANUAL_CONTROL   = 1'b0;
    localparam logic [7:0]  RST_WINDOW_SAMPLES   = 8'd100;
    localparam logic [19:0] RST_LONG_TASK_US     = 20'd10000;
    localparam logic [9:0]  RST_HIGH_LOAD_LIMIT  = 10'd900;
    localparam logic [9:0]  RST_LOW_LOAD_LIMIT   = 10'd850;
    localparam logic [6:0]  RST_ROOM_PER_DIVIDER = 7'd25;

    // divider values
    localparam logic [2:0] DIV_1 = 3'd1;
    localparam logic [2:0] DIV_2 = 3'd2;
    localparam logic [2:0] DIV_4 = 3'd4;

    // bus prescaler codes
    localparam logic [3:0] AHB_DIV1  = 4'b0000;
    localparam logic [3:0] AHB_DIV2  = 4'b1000;
    localparam logic [3:0] AHB_DIV4  = 4'b1001;
    localparam logic [2:0] APB_DIV2  = 3'b100;
    localparam logic [2:0] APB_DIV4  = 3'b101;
    localparam logic [2:0] APB_DIV8  = 3'b110;
    localparam logic [2:0] APB_DIV16 = 3'b111;

    // flash wait states for 216 MHz / divider at 30 MHz per state
    localparam logic [2:0] FWS_DIV1 = 3'd7;
    localparam logic [2:0] FWS_DIV2 = 3'd3;
    localparam logic [2:0] FWS_DIV4 = 3'd1;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] cpu_usage_us;
        logic [31:0] main_task_us;
        logic [7:0]  requested_divider;
    } item_t;

    typedef struct packed {
        logic        manual_control;
        logic [7:0]  window_samples;
        logic [19:0] long_task_us;
        logic [9:0]  high_load_limit;
        logic [9:0]  low_load_limit;
        logic [6:0]  room_per_divider;
    } cfg_t;

    typedef struct packed {
        logic [2:0] flash_wait_states;
        logic [3:0] ahb_code;
        logic [2:0] apb1_code;
        logic [2:0] apb2_code;
    } clk_codes_t;

    typedef struct packed {
        logic       changed;
        logic [2:0] divider;
        clk_codes_t codes;
        logic       latency_first;
    } result_t;

    // saturate to 1..4 and round down to a power of two
    function automatic logic [2:0] round_divider(input logic [7:0] want);
        logic [2:0] d;
        if (want >= 8'd4) begin
            d = DIV_4;
        end else if (want >= 8'd2) begin
            d = DIV_2;
        end else begin
            d = DIV_1;
        end
        return d;
    endfunction

    // wait states and prescaler codes for a divider
    function automatic clk_codes_t clock_codes(input logic [2:0] div);
        clk_codes_t c;
        if (div == DIV_4) begin
            c = '{FWS_DIV4, AHB_DIV4, APB_DIV2, APB_DIV4};
        end else if (div == DIV_2) begin
            c = '{FWS_DIV2, AHB_DIV2, APB_DIV4, APB_DIV8};
        end else begin
            c = '{FWS_DIV1, AHB_DIV1, APB_DIV8, APB_DIV16};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cdg_core.sv =====
// governor state and the single-pass decision logic for one item
`default_nettype none

module cdg_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire cdg_pkg::item_t item,
    input  wire cdg_pkg::cfg_t  cfg,
    output cdg_pkg::result_t    result
);
    import cdg_pkg::*;

    logic [2:0]  div_reg, div_next;
    logic        skip_reg, skip_next;
    logic [15:0] peak_reg, peak_next;
    logic [7:0]  cnt_reg, cnt_next;

    logic [9:0]  room;
    logic [10:0] room2;
    logic [9:0]  hi_val;
    logic [10:0] lo_val;
    logic        hi_ok, lo_ok;
    logic [7:0]  cnt_inc, cnt_s;
    logic [15:0] peak_s;
    logic        new_peak, window_full, hi_cond, lo_cond;
    logic        do_set, change, sped_up;
    logic [7:0]  want;
    logic [2:0]  rounded;

    // thresholds scaled by the current divider
    assign room   = 10'(cfg.room_per_divider) * 10'(div_reg);
    assign room2  = {room, 1'b0};
    assign hi_ok  = cfg.high_load_limit >= room;
    assign hi_val = cfg.high_load_limit - room;
    assign lo_ok  = {1'b0, cfg.low_load_limit} >= room2;
    assign lo_val = {1'b0, cfg.low_load_limit} - room2;

    // sample bookkeeping
    assign cnt_inc     = cnt_reg + 8'd1;
    assign new_peak    = item.cpu_usage_us > peak_reg;
    assign cnt_s       = new_peak ? 8'd0 : cnt_inc;
    assign peak_s      = new_peak ? item.cpu_usage_us : peak_reg;
    assign window_full = cnt_s >= cfg.window_samples;
    assign hi_cond     = hi_ok && (peak_s > 16'(hi_val));
    assign lo_cond     = lo_ok && ({peak_s, 1'b0} < 17'(lo_val));

    // next state per item kind
    always_comb
    begin
        div_next  = div_reg;
        skip_next = skip_reg;
        peak_next = peak_reg;
        cnt_next  = cnt_reg;
        do_set    = 1'b0;
        want      = 8'd1;
        unique case (item.mode)
            MODE_SAMPLE:
            begin
                if (!cfg.manual_control) begin
                    if (skip_reg) begin
                        skip_next = 1'b0;
                    end else begin
                        cnt_next  = cnt_s;
                        peak_next = peak_s;
                        priority if (item.main_task_us > 32'(cfg.long_task_us)) begin
                            do_set = 1'b1;
                            want   = 8'd1;
                        end else if (hi_cond) begin
                            do_set = 1'b1;
                            want   = 8'(div_reg >> 1);
                        end else if (window_full && lo_cond) begin
                            do_set = 1'b1;
                            want   = 8'(div_reg) << 1;
                        end
                        if (window_full) begin
                            cnt_next  = 8'd0;
                            peak_next = 16'd0;
                        end
                    end
                end
            end
            MODE_MAX_PERF:
            begin
                if (!cfg.manual_control) begin
                    cnt_next  = 8'd0;
                    peak_next = 16'd0;
                    do_set    = 1'b1;
                    want      = 8'd1;
                end
            end
            MODE_MANUAL:
            begin
                if (cfg.manual_control) begin
                    do_set = 1'b1;
                    want   = item.requested_divider;
                end
            end
            default:
            begin
            end
        endcase

        rounded = round_divider(want);
        change  = do_set && (rounded != div_reg);
        sped_up = rounded < div_reg;
        if (change) begin
            div_next  = rounded;
            skip_next = 1'b1;
            cnt_next  = 8'd0;
            peak_next = 16'd0;
        end
    end

    // result for this item
    always_comb
    begin
        result.changed       = change;
        result.divider       = div_next;
        result.codes         = clock_codes(div_next);
        result.latency_first = change && sped_up;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            div_reg  <= DIV_1;
            skip_reg <= 1'b0;
            peak_reg <= 16'd0;
            cnt_reg  <= 8'd0;
        end else if (accept) begin
            div_reg  <= div_next;
            skip_reg <= skip_next;
            peak_reg <= peak_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cdg_skid.sv =====
// result register with a skid stage so one more input is taken under a stall
`default_nettype none

module cdg_skid (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire cdg_pkg::result_t in_data,
    output logic                  in_ready,
    output logic                  out_valid,
    output cdg_pkg::result_t      out_data,
    input  wire logic             out_ready
);
    import cdg_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    out_free;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // refill output from skid first, else from the incoming transfer
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_valid;
                out_data_next  = in_data;
            end
        end else if (in_valid && in_ready) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/cpu_clock_divider_governor.sv =====
// top level of the cpu clock divider governor
//
// Input stream (s_*): one item per transfer; s_tuser holds the item kind
// (load sample, back to max performance, manual divider request), s_tdata
// the load figures and the requested divider.
// Output stream (m_*): one result per input item, in order: changed flag,
// divider, flash wait states, AHB/APB1/APB2 prescaler codes and whether the
// wait states go up before the prescalers change.
// Configuration: cfg_we writes cfg_data into register cfg_index at the clock
// edge; no read-back. The user must see that writes are made while no item
// is in flight; the block itself does not enforce it. Throughput: one item
// per cycle while s_tready is up; the divider state is updated in the same
// cycle as the input transfer, so consecutive items chain without gaps.
// Stall: a result register plus one skid entry hold two results; s_tready
// drops only once both are full and returns the cycle after m_tready.
// Reset (rst_n low, asynchronous): divider 1, peak load, sample count and
// skip flag cleared, output empty, registers at their default values.
`default_nettype none

module cpu_clock_divider_governor (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // cpu_usage_us[15:0], main_task_us[47:16], requested_divider[55:48]
    input  wire logic [cdg_pkg::InDataW-1:0]    s_tdata,
    // mode[1:0]
    input  wire logic [1:0]                     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // changed[0], divider[3:1], flash_wait_states[6:4], ahb_code[10:7],
    // apb1_code[13:11], apb2_code[16:14], latency_first[17], zero[23:18]
    output logic [cdg_pkg::OutDataW-1:0]        m_tdata,
    input  wire logic                           cfg_we,
    input  wire logic [cdg_pkg::CfgIndexW-1:0]  cfg_index,
    input  wire logic [cdg_pkg::CfgDataW-1:0]   cfg_data
);
    import cdg_pkg::*;

    cfg_t    cfg_reg;
    item_t   item;
    result_t res_comb;
    result_t res_out;
    logic    accept;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.manual_control   <= RST_MANUAL_CONTROL;
            cfg_reg.window_samples   <= RST_WINDOW_SAMPLES;
            cfg_reg.long_task_us     <= RST_LONG_TASK_US;
            cfg_reg.high_load_limit  <= RST_HIGH_LOAD_LIMIT;
            cfg_reg.low_load_limit   <= RST_LOW_LOAD_LIMIT;
            cfg_reg.room_per_divider <= RST_ROOM_PER_DIVIDER;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MANUAL_CONTROL:   cfg_reg.manual_control   <= cfg_data[0];
                REG_WINDOW_SAMPLES:   cfg_reg.window_samples   <= cfg_data[7:0];
                REG_LONG_TASK_US:     cfg_reg.long_task_us     <= cfg_data[19:0];
                REG_HIGH_LOAD_LIMIT:  cfg_reg.high_load_limit  <= cfg_data[9:0];
                REG_LOW_LOAD_LIMIT:   cfg_reg.low_load_limit   <= cfg_data[9:0];
                REG_ROOM_PER_DIVIDER: cfg_reg.room_per_divider <= cfg_data[6:0];
                default:
                begin
                end
            endcase
        end
    end

    // unpack the input transfer
    assign accept                 = s_tvalid && s_tready;
    assign item.mode              = mode_t'(s_tuser);
    assign item.cpu_usage_us      = s_tdata[15:0];
    assign item.main_task_us      = s_tdata[47:16];
    assign item.requested_divider = s_tdata[55:48];

    cdg_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cfg    (cfg_reg),
        .result (res_comb)
    );

    cdg_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_data   (res_comb),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (res_out),
        .out_ready (m_tready)
    );

    // pack the result, lowest field first
    assign m_tdata = {6'd0,
                      res_out.latency_first,
                      res_out.codes.apb2_code,
                      res_out.codes.apb1_code,
                      res_out.codes.ahb_code,
                      res_out.codes.flash_wait_states,
                      res_out.divider,
                      res_out.changed};

endmodule

`default_nettype wire

// ===== rtl/core/cdg_checker.sv =====
// port-level checks for the governor, bound to the top level
`default_nettype none

module cdg_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [cdg_pkg::OutDataW-1:0]   m_tdata
);
    import cdg_pkg::*;

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // an offered divider is always one of the legal values
    a_div_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3:1] == DIV_1 || m_tdata[3:1] == DIV_2 ||
                      m_tdata[3:1] == DIV_4))
        else $error("illegal divider");

    // wait-state ordering only flagged on a divider change
    a_latency_first: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> !m_tdata[17])
        else $error("latency_first without change");

endmodule

bind cpu_clock_divider_governor cdg_checker u_cdg_checker (.*);

`default_nettype wire

// ===== tb/tb_cpu_clock_divider_governor.sv =====
// self-checking testbench for the cpu clock divider governor stream block
module tb_cpu_clock_divider_governor;
    import cdg_pkg::*;

    localparam logic [1:0] MODE_UNDEFINED = 2'd3;
    localparam int CycleLimit = 200000;
    localparam int HoldCycles = 80;

    // one expected report, fields as the block emits them
    typedef struct packed {
        logic       changed;
        logic [2:0] divider;
        logic [2:0] flash_wait_states;
        logic [3:0] ahb_code;
        logic [2:0] apb1_code;
        logic [2:0] apb2_code;
        logic       latency_first;
    } div_report_t;

    // directed step: either a register write or an item with an optional fixed answer
    typedef struct {
        bit          is_cfg;
        logic [1:0]  mode;
        logic [15:0] usage;
        logic [31:0] run_us;
        logic [7:0]  req;
        reg_idx_t    reg_idx;
        logic [19:0] reg_val;
        bit          typed;
        bit          exp_changed;
        logic [2:0]  exp_div;
        bit          exp_faster;
    } gov_row_t;

    // what is known about an item before it is accepted
    typedef struct {
        bit          typed;
        div_report_t report;
    } offer_tag_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [InDataW-1:0]    s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OutDataW-1:0]   m_tdata;
    logic                  cfg_we;
    logic [CfgIndexW-1:0]  cfg_index;
    logic [CfgDataW-1:0]   cfg_data;

    // governor state mirrored by the testbench
    cfg_t        gov_cfg;
    logic [2:0]  div_now;
    logic        skip_sample;
    logic [15:0] peak_load;
    logic [7:0]  window_count;
    bit          changed_now;
    bit          faster_now;

    offer_tag_t  offer_tags_q[$];
    div_report_t div_reports_q[$];
    gov_row_t    script[$];

    int  errors;
    int  cycles;
    int  items_sent;
    int  reports_checked;
    int  divider_moves;
    bit  jitter_on;
    bit  hold_req;
    int  hold_left;

    cpu_clock_divider_governor uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock, period 2
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("cpu_clock_divider_governor: mismatch");
            $finish;
        end
    end

    // wait states and prescaler codes for a divider
    function automatic div_report_t report_for(logic [2:0] div, bit changed, bit faster);
        div_report_t r;
        r.changed = changed;
        r.divider = div;
        r.latency_first = faster;
        case (div)
            DIV_4:
            begin
                r.flash_wait_states = FWS_DIV4;
                r.ahb_code = AHB_DIV4;
                r.apb1_code = APB_DIV2;
                r.apb2_code = APB_DIV4;
            end
            DIV_2:
            begin
                r.flash_wait_states = FWS_DIV2;
                r.ahb_code = AHB_DIV2;
                r.apb1_code = APB_DIV4;
                r.apb2_code = APB_DIV8;
            end
            default:
            begin
                r.flash_wait_states = FWS_DIV1;
                r.ahb_code = AHB_DIV1;
                r.apb1_code = APB_DIV8;
                r.apb2_code = APB_DIV16;
            end
        endcase
        return r;
    endfunction

    // saturate, round down to a power of two, and restart the load window on a change
    function automatic void retarget_divider(int want);
        logic [2:0] d;
        if (want >= 4)
            d = DIV_4;
        else if (want >= 2)
            d = DIV_2;
        else
            d = DIV_1;
        if (d != div_now)
        begin
            faster_now = (d < div_now);
            changed_now = 1'b1;
            div_now = d;
            skip_sample = 1'b1;
            window_count = '0;
            peak_load = '0;
        end
    endfunction

    // next governor state and the report for one accepted item
    function automatic div_report_t advance_governor(logic [1:0] mode, logic [15:0] usage,
                                                     logic [31:0] run_us, logic [7:0] req);
        int room;
        int hi;
        int lo;
        changed_now = 1'b0;
        faster_now = 1'b0;
        case (mode)
            MODE_SAMPLE:
            begin
                if (!gov_cfg.manual_control)
                begin
                    if (skip_sample)
                        skip_sample = 1'b0;
                    else
                    begin
                        window_count = window_count + 8'd1;
                        if (usage > peak_load)
                        begin
                            peak_load = usage;
                            window_count = '0;
                        end
                        room = int'(gov_cfg.room_per_divider) * int'(div_now);
                        hi = int'(gov_cfg.high_load_limit) - room;
                        lo = int'(gov_cfg.low_load_limit) - 2 * room;
                        if (run_us > {12'd0, gov_cfg.long_task_us})
                            retarget_divider(1);
                        else if (hi >= 0 && int'(peak_load) > hi)
                            retarget_divider(int'(div_now) / 2);
                        else if (window_count >= gov_cfg.window_samples && lo >= 0 &&
                                 2 * int'(peak_load) < lo)
                            retarget_divider(int'(div_now) * 2);
                        if (window_count >= gov_cfg.window_samples)
                        begin
                            window_count = '0;
                            peak_load = '0;
                        end
                    end
                end
            end
            MODE_MAX_PERF:
            begin
                if (!gov_cfg.manual_control)
                begin
                    peak_load = '0;
                    window_count = '0;
                    retarget_divider(1);
                end
            end
            MODE_MANUAL:
            begin
                if (gov_cfg.manual_control)
                    retarget_divider(int'(req));
            end
            default:
            begin
            end
        endcase
        return report_for(div_now, changed_now, changed_now && faster_now);
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function automatic gov_row_t row_item(logic [1:0] mode, logic [15:0] usage,
                                          logic [31:0] run_us, logic [7:0] req, bit typed,
                                          bit chg, logic [2:0] div, bit faster);
        gov_row_t r;
        r.is_cfg = 1'b0;
        r.mode = mode;
        r.usage = usage;
        r.run_us = run_us;
        r.req = req;
        r.reg_idx = REG_MANUAL_CONTROL;
        r.reg_val = '0;
        r.typed = typed;
        r.exp_changed = chg;
        r.exp_div = div;
        r.exp_faster = faster;
        return r;
    endfunction

    function automatic gov_row_t row_cfg(reg_idx_t idx, logic [19:0] val);
        gov_row_t r;
        r = row_item(MODE_SAMPLE, '0, '0, '0, 1'b0, 1'b0, DIV_1, 1'b0);
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // accepted items feed the predictor, accepted results are checked in order
    always @(posedge clk)
    begin
        offer_tag_t  tag;
        div_report_t want;
        div_report_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                tag = offer_tags_q.pop_front();
                want = advance_governor(s_tuser, s_tdata[15:0], s_tdata[47:16], s_tdata[55:48]);
                if (tag.typed)
                    want = tag.report;
                div_reports_q.push_back(want);
                items_sent++;
            end
            if (m_tvalid && m_tready)
            begin
                if (div_reports_q.size() == 0)
                begin
                    $error("result transfer with no item outstanding");
                    errors++;
                end
                else
                begin
                    want = div_reports_q.pop_front();
                    got.changed = m_tdata[0];
                    got.divider = m_tdata[3:1];
                    got.flash_wait_states = m_tdata[6:4];
                    got.ahb_code = m_tdata[10:7];
                    got.apb1_code = m_tdata[13:11];
                    got.apb2_code = m_tdata[16:14];
                    got.latency_first = m_tdata[17];
                    check_field("changed", int'(want.changed), int'(got.changed));
                    check_field("divider", int'(want.divider), int'(got.divider));
                    check_field("flash_wait_states", int'(want.flash_wait_states),
                                int'(got.flash_wait_states));
                    check_field("ahb_code", int'(want.ahb_code), int'(got.ahb_code));
                    check_field("apb1_code", int'(want.apb1_code), int'(got.apb1_code));
                    check_field("apb2_code", int'(want.apb2_code), int'(got.apb2_code));
                    check_field("latency_first", int'(want.latency_first),
                                int'(got.latency_first));
                    reports_checked++;
                    if (want.changed)
                        divider_moves++;
                end
            end
        end
    end

    // result side: random stalls plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HoldCycles;
            hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (jitter_on && $urandom_range(99) < 19)
            m_tready <= 1'b0;
        else
            m_tready <= 1'b1;
    end

    // offer one item, with random gaps, until it is taken
    task automatic offer_item(logic [1:0] mode, logic [15:0] usage, logic [31:0] run_us,
                              logic [7:0] req, offer_tag_t tag);
        while (jitter_on && $urandom_range(99) < 19)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        offer_tags_q.push_back(tag);
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {req, run_us, usage};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (div_reports_q.size() != 0 && waited < 5000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (3) @(negedge clk);
    endtask

    // register write, mirrored in the predictor configuration
    task automatic write_reg(reg_idx_t idx, logic [19:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_MANUAL_CONTROL:   gov_cfg.manual_control = val[0];
            REG_WINDOW_SAMPLES:   gov_cfg.window_samples = val[7:0];
            REG_LONG_TASK_US:     gov_cfg.long_task_us = val[19:0];
            REG_HIGH_LOAD_LIMIT:  gov_cfg.high_load_limit = val[9:0];
            REG_LOW_LOAD_LIMIT:   gov_cfg.low_load_limit = val[9:0];
            REG_ROOM_PER_DIVIDER: gov_cfg.room_per_divider = val[6:0];
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // random traffic until enough items have had an effect
    task automatic run_phase(int target, bit squeeze);
        int          useful;
        int          sent;
        int          pick;
        logic [1:0]  mode;
        logic [15:0] usage;
        logic [31:0] run_us;
        logic [7:0]  req;
        offer_tag_t  tag;
        useful = 0;
        sent = 0;
        tag.typed = 1'b0;
        tag.report = '0;
        while (useful < target)
        begin
            pick = $urandom_range(99);
            if (gov_cfg.manual_control)
                mode = (pick < 60) ? MODE_MANUAL : (pick < 80) ? MODE_SAMPLE :
                       (pick < 95) ? MODE_MAX_PERF : MODE_UNDEFINED;
            else
                mode = (pick < 84) ? MODE_SAMPLE : (pick < 90) ? MODE_MAX_PERF :
                       (pick < 95) ? MODE_MANUAL : MODE_UNDEFINED;
            // load mostly near the thresholds, sometimes at the extremes
            pick = $urandom_range(99);
            if (pick < 45)
                usage = 16'($urandom_range(200));
            else if (pick < 75)
                usage = 16'($urandom_range(1100));
            else if (pick < 80)
                usage = 16'd0;
            else if (pick < 85)
                usage = 16'hFFFF;
            else
                usage = 16'($urandom);
            // main task mostly short, sometimes just over the limit
            pick = $urandom_range(99);
            if (pick < 20)
                run_us = '0;
            else if (pick < 85)
                run_us = $urandom_range(int'(gov_cfg.long_task_us));
            else if (pick < 95)
                run_us = {12'd0, gov_cfg.long_task_us} + 32'd1 + $urandom_range(1000);
            else
                run_us = $urandom;
            req = ($urandom_range(1) == 0) ? 8'($urandom_range(5)) : 8'($urandom);
            offer_item(mode, usage, run_us, req, tag);
            sent++;
            if (squeeze && sent == 30)
                hold_req = 1'b1;
            if (!(mode == MODE_UNDEFINED ||
                  (gov_cfg.manual_control && mode != MODE_MANUAL) ||
                  (!gov_cfg.manual_control && mode == MODE_MANUAL)))
                useful++;
        end
    endtask

    initial
    begin
        cfg_t       next;
        cfg_t       plan[5];
        offer_tag_t tag;

        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        cycles = 0;
        items_sent = 0;
        reports_checked = 0;
        divider_moves = 0;
        jitter_on = 1'b1;
        hold_req = 1'b0;
        hold_left = 0;
        gov_cfg = '{RST_MANUAL_CONTROL, RST_WINDOW_SAMPLES, RST_LONG_TASK_US,
                    RST_HIGH_LOAD_LIMIT, RST_LOW_LOAD_LIMIT, RST_ROOM_PER_DIVIDER};
        div_now = DIV_1;
        skip_sample = 1'b0;
        peak_load = '0;
        window_count = '0;

        // fixed settings: quick window, manual, both extremes, negative thresholds
        plan[0] = '{1'b0, 8'd3, 20'd5000, 10'd600, 10'd900, 7'd25};
        plan[1] = '{1'b1, 8'd100, 20'd10000, 10'd900, 10'd850, 7'd25};
        plan[2] = '{1'b0, 8'd255, 20'd1000000, 10'd1000, 10'd1000, 7'd100};
        plan[3] = '{1'b0, 8'd1, 20'd0, 10'd0, 10'd0, 7'd0};
        plan[4] = '{1'b0, 8'd2, 20'd1000000, 10'd300, 10'd700, 7'd100};

        // directed steps from reset defaults
        script.push_back(row_item(MODE_MAX_PERF, 16'd0, 32'd0, 8'd0, 1, 0, DIV_1, 0));
        script.push_back(row_item(MODE_SAMPLE, 16'd0, 32'd0, 8'd0, 1, 0, DIV_1, 0));
        script.push_back(row_item(MODE_SAMPLE, 16'hFFFF, 32'd0, 8'd0, 1, 0, DIV_1, 0));
        script.push_back(row_item(MODE_SAMPLE, 16'd0, 32'hFFFFFFFF, 8'd0, 1, 0, DIV_1, 0));
        script.push_back(row_item(MODE_MANUAL, 16'd0, 32'd0, 8'd4, 1, 0, DIV_1, 0));
        script.push_back(row_item(MODE_UNDEFINED, 16'hFFFF, 32'hFFFFFFFF, 8'hFF,
                                  1, 0, DIV_1, 0));
        script.push_back(row_cfg(REG_MANUAL_CONTROL, 20'd1));
        script.push_back(row_item(MODE_MANUAL, 16'd0, 32'd0, 8'd0, 1, 0, DIV_1, 0));
        script.push_back(row_item(MODE_MANUAL, 16'd0, 32'd0, 8'd255, 1, 1, DIV_4, 0));
        script.push_back(row_item(MODE_MANUAL, 16'd0, 32'd0, 8'd3, 1, 1, DIV_2, 1));
        script.push_back(row_item(MODE_MANUAL, 16'd0, 32'd0, 8'd2, 1, 0, DIV_2, 0));
        script.push_back(row_item(MODE_SAMPLE, 16'hFFFF, 32'hFFFFFFFF, 8'd0, 1, 0, DIV_2, 0));
        script.push_back(row_item(MODE_MAX_PERF, 16'd0, 32'd0, 8'd0, 1, 0, DIV_2, 0));
        script.push_back(row_item(MODE_MANUAL, 16'd0, 32'd0, 8'd1, 1, 1, DIV_1, 1));
        script.push_back(row_item(MODE_MANUAL, 16'd0, 32'd0, 8'd4, 1, 1, DIV_4, 0));
        script.push_back(row_cfg(REG_MANUAL_CONTROL, 20'd0));
        script.push_back(row_cfg(REG_WINDOW_SAMPLES, 20'd1));
        // skip flag eats the first sample after a change
        script.push_back(row_item(MODE_SAMPLE, 16'd0, 32'd0, 8'd0, 1, 0, DIV_4, 0));
        // doubling at divider 4 saturates
        script.push_back(row_item(MODE_SAMPLE, 16'd0, 32'd0, 8'd0, 1, 0, DIV_4, 0));
        script.push_back(row_item(MODE_SAMPLE, 16'd1000, 32'd0, 8'd0, 1, 1, DIV_2, 1));
        script.push_back(row_item(MODE_SAMPLE, 16'd0, 32'd0, 8'd0, 1, 0, DIV_2, 0));
        script.push_back(row_item(MODE_SAMPLE, 16'd10, 32'd0, 8'd0, 0, 0, DIV_2, 0));
        script.push_back(row_item(MODE_SAMPLE, 16'd5, 32'd0, 8'd0, 0, 0, DIV_4, 0));
        script.push_back(row_item(MODE_MAX_PERF, 16'd0, 32'd0, 8'd0, 1, 1, DIV_1, 1));
        script.push_back(row_item(MODE_SAMPLE, 16'd0, 32'd0, 8'd0, 1, 0, DIV_1, 0));
        script.push_back(row_item(MODE_SAMPLE, 16'd0, 32'd20000, 8'd0, 0, 0, DIV_1, 0));

        // reset held low, then released on a falling edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part
        foreach (script[i])
        begin
            if (script[i].is_cfg)
            begin
                drain();
                write_reg(script[i].reg_idx, script[i].reg_val);
            end
            else
            begin
                tag.typed = script[i].typed;
                tag.report = report_for(script[i].exp_div, script[i].exp_changed,
                                        script[i].exp_faster);
                offer_item(script[i].mode, script[i].usage, script[i].run_us,
                           script[i].req, tag);
            end
        end
        drain();

        // random part over fixed and random settings; first phase runs without stalls
        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph < 5)
                next = plan[ph];
            else
            begin
                next.manual_control = ($urandom_range(3) == 0);
                next.window_samples = 8'($urandom_range(1, 8));
                next.long_task_us = 20'($urandom_range(1000000));
                next.high_load_limit = 10'($urandom_range(1000));
                next.low_load_limit = 10'($urandom_range(1000));
                next.room_per_divider = 7'($urandom_range(100));
            end
            write_reg(REG_MANUAL_CONTROL, 20'(next.manual_control));
            write_reg(REG_WINDOW_SAMPLES, 20'(next.window_samples));
            write_reg(REG_LONG_TASK_US, next.long_task_us);
            write_reg(REG_HIGH_LOAD_LIMIT, 20'(next.high_load_limit));
            write_reg(REG_LOW_LOAD_LIMIT, 20'(next.low_load_limit));
            write_reg(REG_ROOM_PER_DIVIDER, 20'(next.room_per_divider));
            jitter_on = (ph != 0);
            run_phase((ph >= 1 && ph <= 4) ? 125 : 165, ph == 2);
            drain();
        end

        repeat (4) @(posedge clk);
        if (div_reports_q.size() != 0)
        begin
            $error("%0d results never arrived", div_reports_q.size());
            errors++;
        end
        $display("ran %0d items through reset defaults, 9 register settings and a long stall",
                 items_sent);
        $display("checked %0d results, %0d of them with a divider change, %0d errors",
                 reports_checked, divider_moves, errors);
        if (errors == 0)
            $display("cpu_clock_divider_governor: match");
        else
            $display("cpu_clock_divider_governor: mismatch");
        $finish;
    end

endmodule
